// File: rtl/lss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LIFO stack with search.
// No dependencies; used by lifo_stack_with_search and the bench.
package lss_pkg;

  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int RANK_W   = 5;
  localparam int FREQ_W   = 6;
  localparam int OCC_W    = 6;

  localparam logic [OP_W-1:0] OpPush   = 2'd0;
  localparam logic [OP_W-1:0] OpPop    = 2'd1;
  localparam logic [OP_W-1:0] OpSearch = 2'd2;
  localparam logic [OP_W-1:0] OpClear  = 2'd3;

  localparam logic [STATUS_W-1:0] StDone  = 3'd0;
  localparam logic [STATUS_W-1:0] StEmpty = 3'd1;
  localparam logic [STATUS_W-1:0] StFull  = 3'd2;
  localparam logic [STATUS_W-1:0] StMatch = 3'd3;
  localparam logic [STATUS_W-1:0] StTotal = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [RANK_W-1:0]         rank;
    logic [FREQ_W-1:0]         frequency;
    logic signed [VALUE_W-1:0] top_value;
    logic [OCC_W-1:0]          occupancy;
    logic                      is_empty;
    logic                      last;
  } res_t;

endpackage

// File: rtl/lss_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lss_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lifo_stack_with_search.sv
`timescale 1ns / 1ps
// Top level of the LIFO stack with search: sequencer, count and top registers.
// Depends on lss_pkg and lss_ram.
//
// Usage:
//   A request (operation, value on req_i) is taken at a clock edge where
//   start is high and busy is low. Results come out on res_o, one cycle
//   each, marked by valid_o; the receiver cannot hold them off.
//   Push, clear, pop or search on an empty stack, and pop of the last entry:
//   one result from the result register; busy stays low, so a request can
//   follow every cycle.
//   Pop that leaves entries behind: the new top is read from the entry RAM
//   and registered into the result in state S_POP (busy for one cycle).
//   Search: the compare unit walks the entries from the top, one entry per
//   cycle through the RAM read port. Each match gives a result as it is
//   found; the total follows after the last entry. The next request is
//   taken once the S_SRCH and S_TOTAL states have finished.
//   Every result carries the top word, the occupancy and an empty flag;
//   last marks the final result of a request.
//   Reset empties the stack at once; entry contents are not cleared.
module lifo_stack_with_search (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lss_pkg::req_t req_i,
  output logic          valid_o,
  output lss_pkg::res_t res_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_SRCH  = 2'd2;
  localparam logic [1:0] S_TOTAL = 2'd3;

  logic [1:0]                       state_q, state_d;
  logic [lss_pkg::CNT_W-1:0]        count_q, count_d;
  logic [lss_pkg::DATA_WIDTH-1:0]   top_q, top_d;
  logic [lss_pkg::DATA_WIDTH-1:0]   val_q, val_d;
  logic [lss_pkg::ADDR_W-1:0]       rank_q, rank_d;
  logic [lss_pkg::CNT_W-1:0]        freq_q, freq_d;
  logic                             valid_q, valid_d;
  lss_pkg::res_t                    res_q, res_d;

  logic                             ram_we;
  logic [lss_pkg::ADDR_W-1:0]       ram_waddr;
  logic [lss_pkg::DATA_WIDTH-1:0]   ram_wdata;
  logic [lss_pkg::ADDR_W-1:0]       ram_raddr;
  logic [lss_pkg::DATA_WIDTH-1:0]   ram_rdata;
  logic                             hit;
  logic                             last_cmp;

  function automatic lss_pkg::res_t mk_res(
    input logic [lss_pkg::STATUS_W-1:0]   status,
    input logic [lss_pkg::RANK_W-1:0]     rank,
    input logic [lss_pkg::CNT_W-1:0]      freq,
    input logic [lss_pkg::CNT_W-1:0]      cnt,
    input logic [lss_pkg::DATA_WIDTH-1:0] top,
    input logic                           last
  );
    lss_pkg::res_t r;
    r.status    = status;
    r.rank      = rank;
    r.frequency = lss_pkg::FREQ_W'(freq);
    r.top_value = (cnt == '0) ? '0 : lss_pkg::VALUE_W'(top);
    r.occupancy = lss_pkg::OCC_W'(cnt);
    r.is_empty  = (cnt == '0);
    r.last      = last;
    return r;
  endfunction

  lss_ram #(
    .Width (lss_pkg::DATA_WIDTH),
    .Depth (lss_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy     = (state_q != S_IDLE);
  assign hit      = (ram_rdata == val_q);
  assign last_cmp = (lss_pkg::CNT_W'(rank_q) == count_q - lss_pkg::CNT_W'(1));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    top_d     = top_q;
    val_d     = val_q;
    rank_d    = rank_q;
    freq_d    = freq_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = lss_pkg::ADDR_W'(count_q);
    ram_wdata = lss_pkg::DATA_WIDTH'(req_i.value);
    ram_raddr = lss_pkg::ADDR_W'(count_q - lss_pkg::CNT_W'(1));
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          valid_d = 1'b1;
          unique case (req_i.operation)
            lss_pkg::OpPush: begin
              if (count_q == lss_pkg::CNT_W'(lss_pkg::DEPTH)) begin
                res_d = mk_res(lss_pkg::StFull, '0, '0, count_q, top_q, 1'b1);
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + lss_pkg::CNT_W'(1);
                top_d   = ram_wdata;
                res_d   = mk_res(lss_pkg::StDone, '0, '0, count_d, ram_wdata, 1'b1);
              end
            end
            lss_pkg::OpPop: begin
              if (count_q == '0) begin
                res_d = mk_res(lss_pkg::StEmpty, '0, '0, count_q, top_q, 1'b1);
              end else begin
                count_d = count_q - lss_pkg::CNT_W'(1);
                if (count_q == lss_pkg::CNT_W'(1)) begin
                  res_d = mk_res(lss_pkg::StDone, '0, '0, count_d, top_q, 1'b1);
                end else begin
                  // fetch the new top
                  ram_raddr = lss_pkg::ADDR_W'(count_q - lss_pkg::CNT_W'(2));
                  valid_d   = 1'b0;
                  state_d   = S_POP;
                end
              end
            end
            lss_pkg::OpSearch: begin
              if (count_q == '0) begin
                res_d = mk_res(lss_pkg::StEmpty, '0, '0, count_q, top_q, 1'b1);
              end else begin
                valid_d = 1'b0;
                val_d   = lss_pkg::DATA_WIDTH'(req_i.value);
                rank_d  = '0;
                freq_d  = '0;
                state_d = S_SRCH;
              end
            end
            lss_pkg::OpClear: begin
              count_d = '0;
              res_d   = mk_res(lss_pkg::StDone, '0, '0, '0, top_q, 1'b1);
            end
            default: begin
              valid_d = 1'b0;
            end
          endcase
        end
      end
      S_POP: begin
        top_d   = ram_rdata;
        valid_d = 1'b1;
        res_d   = mk_res(lss_pkg::StDone, '0, '0, count_q, ram_rdata, 1'b1);
        state_d = S_IDLE;
      end
      S_SRCH: begin
        // prefetch the entry one below the one being compared
        ram_raddr = lss_pkg::ADDR_W'(count_q - lss_pkg::CNT_W'(2)
                                     - lss_pkg::CNT_W'(rank_q));
        if (hit) begin
          valid_d = 1'b1;
          freq_d  = freq_q + lss_pkg::CNT_W'(1);
          res_d   = mk_res(lss_pkg::StMatch, lss_pkg::RANK_W'(rank_q), '0, count_q,
                           top_q, 1'b0);
        end
        if (last_cmp) begin
          state_d = S_TOTAL;
        end else begin
          rank_d = rank_q + lss_pkg::ADDR_W'(1);
        end
      end
      S_TOTAL: begin
        valid_d = 1'b1;
        res_d   = mk_res(lss_pkg::StTotal, '0, freq_q, count_q, top_q, 1'b1);
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    val_q  <= val_d;
    rank_q <= rank_d;
    freq_q <= freq_d;
    res_q  <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lifo_stack_with_search: a directed request table, then
// random request streams checked against a behavioral stack model. Needs lss_pkg and the RTL.
module tb;
  import lss_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = DEPTH + 8;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic               pin;
    res_t               want;
  } row_t;

  localparam res_t NoPin = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic valid_o;
  res_t res_o;

  // typed expectation travels with the request it belongs to
  logic pin_valid = 1'b0;
  res_t pin_res = '0;

  logic [DATA_WIDTH-1:0] stack_mem [DEPTH];
  int unsigned stack_cnt = 0;
  res_t expected_q [$];
  logic [VALUE_W-1:0] pool [4];

  int idle_pct = 0;
  int n_err = 0;
  int n_req = 0;
  int n_res = 0;
  int n_match = 0;
  int n_full = 0;
  int n_empty = 0;
  int peak_freq = 0;
  int n_cycles = 0;

  lifo_stack_with_search i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic res_t stack_result(logic [STATUS_W-1:0] st, int unsigned rank,
                                        int unsigned freq, logic is_last);
    res_t r;
    r.status    = st;
    r.rank      = RANK_W'(rank);
    r.frequency = FREQ_W'(freq);
    r.top_value = (stack_cnt == 0) ? '0 : stack_mem[stack_cnt - 1];
    r.occupancy = OCC_W'(stack_cnt);
    r.is_empty  = (stack_cnt == 0);
    r.last      = is_last;
    return r;
  endfunction

  function automatic res_t pinned(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] top, int occ);
    res_t r;
    r.status    = st;
    r.rank      = '0;
    r.frequency = '0;
    r.top_value = top;
    r.occupancy = OCC_W'(occ);
    r.is_empty  = (occ == 0);
    r.last      = 1'b1;
    return r;
  endfunction

  task automatic predict_request(input req_t r);
    int unsigned freq = 0;
    case (r.operation)
      OpPush: begin
        if (stack_cnt >= DEPTH) begin
          expected_q.push_back(stack_result(StFull, 0, 0, 1'b1));
        end else begin
          stack_mem[stack_cnt] = DATA_WIDTH'(r.value);
          stack_cnt++;
          expected_q.push_back(stack_result(StDone, 0, 0, 1'b1));
        end
      end
      OpPop: begin
        if (stack_cnt == 0) begin
          expected_q.push_back(stack_result(StEmpty, 0, 0, 1'b1));
        end else begin
          stack_cnt--;
          expected_q.push_back(stack_result(StDone, 0, 0, 1'b1));
        end
      end
      OpSearch: begin
        if (stack_cnt == 0) begin
          expected_q.push_back(stack_result(StEmpty, 0, 0, 1'b1));
        end else begin
          for (int unsigned k = 0; k < stack_cnt; k++) begin
            if (stack_mem[stack_cnt - 1 - k] == DATA_WIDTH'(r.value)) begin
              freq++;
              expected_q.push_back(stack_result(StMatch, k, 0, 1'b0));
            end
          end
          expected_q.push_back(stack_result(StTotal, 0, freq, 1'b1));
        end
      end
      OpClear: begin
        stack_cnt = 0;
        expected_q.push_back(stack_result(StDone, 0, 0, 1'b1));
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (n_err < 40) $display("%0t ns: %s got %0h, want %0h", $realtime, what, got, want);
    n_err++;
  endtask

  always @(posedge clk_i) begin : check_p
    res_t want;
    if (rst_ni) begin
      if (valid_o) begin
        n_res++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, status", res_o.status, 0);
        end else begin
          want = expected_q.pop_front();
          if (res_o.status !== want.status) report_mismatch("status", res_o.status, want.status);
          if (res_o.rank !== want.rank) report_mismatch("rank", res_o.rank, want.rank);
          if (res_o.frequency !== want.frequency)
            report_mismatch("frequency", res_o.frequency, want.frequency);
          if (res_o.top_value !== want.top_value)
            report_mismatch("top_value", res_o.top_value, want.top_value);
          if (res_o.occupancy !== want.occupancy)
            report_mismatch("occupancy", res_o.occupancy, want.occupancy);
          if (res_o.is_empty !== want.is_empty)
            report_mismatch("is_empty", res_o.is_empty, want.is_empty);
          if (res_o.last !== want.last) report_mismatch("last", res_o.last, want.last);
          if (want.status == StMatch) n_match++;
          if (want.status == StFull) n_full++;
          if (want.status == StEmpty) n_empty++;
          if (want.status == StTotal && want.frequency > peak_freq) peak_freq = want.frequency;
        end
      end
      if (start && !busy) begin
        n_req++;
        predict_request(req_i);
        if (pin_valid) begin
          void'(expected_q.pop_back());
          expected_q.push_back(pin_res);
        end
      end
    end
  end

  function automatic logic [VALUE_W-1:0] rand_value();
    if ($urandom_range(99) < 60) return pool[$urandom_range(3)];
    return $urandom;
  endfunction

  task automatic send_req(input row_t row);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    req_i.operation <= row.op;
    req_i.value     <= row.value;
    pin_valid       <= row.pin;
    pin_res         <= row.want;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin : watchdog_p
    while (n_cycles < CycleLimit) begin
      @(posedge clk_i);
      n_cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", n_cycles, expected_q.size());
    $display("FAIL lifo_stack_with_search");
    $finish;
  end

  initial begin : stim_p
    row_t dir_rows [$];
    logic [VALUE_W-1:0] fill_val;
    int r;

    foreach (pool[i]) pool[i] = $urandom;

    dir_rows.push_back({OpPop, 32'h0000_0000, 1'b1, pinned(StEmpty, '0, 0)});
    dir_rows.push_back({OpSearch, 32'h0000_0000, 1'b1, pinned(StEmpty, '0, 0)});
    dir_rows.push_back({OpPush, 32'h7FFF_FFFF, 1'b1, pinned(StDone, 32'h7FFF_FFFF, 1)});
    dir_rows.push_back({OpPush, 32'h8000_0000, 1'b1, pinned(StDone, 32'h8000_0000, 2)});
    dir_rows.push_back({OpPush, 32'h0000_0000, 1'b1, pinned(StDone, 32'h0000_0000, 3)});
    dir_rows.push_back({OpPush, 32'hFFFF_FFFF, 1'b1, pinned(StDone, 32'hFFFF_FFFF, 4)});
    dir_rows.push_back({OpPush, 32'h8000_0000, 1'b1, pinned(StDone, 32'h8000_0000, 5)});
    dir_rows.push_back({OpSearch, 32'h8000_0000, 1'b0, NoPin});
    dir_rows.push_back({OpSearch, 32'h1234_5678, 1'b1, pinned(StTotal, 32'h8000_0000, 5)});
    dir_rows.push_back({OpSearch, 32'h7FFF_FFFF, 1'b0, NoPin});
    dir_rows.push_back({OpSearch, 32'h0000_0000, 1'b0, NoPin});
    dir_rows.push_back({OpPop, 32'hFFFF_FFFF, 1'b0, NoPin});
    dir_rows.push_back({OpPop, 32'h0000_0000, 1'b0, NoPin});
    dir_rows.push_back({OpSearch, 32'hFFFF_FFFF, 1'b0, NoPin});
    dir_rows.push_back({OpClear, 32'hFFFF_FFFF, 1'b1, pinned(StDone, '0, 0)});
    dir_rows.push_back({OpPop, 32'h0000_0001, 1'b1, pinned(StEmpty, '0, 0)});
    dir_rows.push_back({OpSearch, 32'hFFFF_FFFF, 1'b1, pinned(StEmpty, '0, 0)});
    dir_rows.push_back({OpClear, 32'h0000_0000, 1'b1, pinned(StDone, '0, 0)});
    dir_rows.push_back({OpPush, 32'h5A5A_A5A5, 1'b1, pinned(StDone, 32'h5A5A_A5A5, 1)});
    dir_rows.push_back({OpPop, 32'h0000_0000, 1'b1, pinned(StDone, '0, 0)});
    dir_rows.push_back({OpPush, 32'hA5A5_5A5A, 1'b0, NoPin});
    dir_rows.push_back({OpPush, 32'hA5A5_5A5A, 1'b0, NoPin});
    dir_rows.push_back({OpSearch, 32'hA5A5_5A5A, 1'b0, NoPin});
    dir_rows.push_back({OpClear, 32'h0000_0000, 1'b0, NoPin});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 26;
    foreach (dir_rows[i]) send_req(dir_rows[i]);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 26 : (ph == 1) ? 66 : 0;
      // phases 0 and 2: fill past full and search a deep stack; every phase: a random mix
      if (ph != 1) begin
        fill_val = pool[$urandom_range(3)];
        send_req({OpClear, 32'($urandom), 1'b0, NoPin});
        repeat (DEPTH + 2)
          send_req({OpPush, (ph == 0 || $urandom_range(1) == 0) ? fill_val : rand_value(),
                    1'b0, NoPin});
        send_req({OpSearch, fill_val, 1'b0, NoPin});
        send_req({OpSearch, rand_value(), 1'b0, NoPin});
      end
      repeat ((ph == 1) ? 50 : 20) begin
        r = $urandom_range(99);
        send_req({(r < 45) ? OpPush : (r < 70) ? OpPop : (r < 92) ? OpSearch : OpClear,
                  rand_value(), 1'b0, NoPin});
      end
    end

    start     <= 1'b0;
    pin_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d requests, checked %0d results in %0d cycles", n_req, n_res, n_cycles);
    $display("saw %0d matches (deepest search total %0d), %0d full and %0d empty statuses",
             n_match, peak_freq, n_full, n_empty);
    if (n_err == 0) begin
      $display("PASS lifo_stack_with_search");
    end else begin
      $display("%0d mismatches", n_err);
      $display("FAIL lifo_stack_with_search");
    end
    $finish;
  end

endmodule
